FILE: hw/rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

  localparam int MESSAGE_COUNT_BITS = 32;
  localparam int SUM_BITS = 65;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR1    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_PROTO = 2'd2,
    ST_BIG   = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       final_frame;
  } result_t;

endpackage

FILE: hw/rtl/wsfd_parser.sv
// Frame parser: header, length, key and payload state with per-byte result.
module wsfd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  cfg_write,
  input  logic [31:0]           cfg_limit,
  output logic                  res_valid,
  output wsfd_pkg::result_t     res
);

  localparam int CB = wsfd_pkg::MESSAGE_COUNT_BITS;
  localparam int SB = wsfd_pkg::SUM_BITS;

  wsfd_pkg::phase_t phase, phase_next;
  logic          fin_seen, fin_seen_next;
  logic [3:0]    cur_op, cur_op_next;
  logic          masked, masked_next;
  logic [3:0]    ext_left, ext_left_next;
  logic [63:0]   frame_length, frame_length_next;
  logic [63:0]   bytes_left, bytes_left_next;
  logic [1:0]    key_idx, key_idx_next;
  logic [31:0]   key_word, key_word_next;
  logic [2:0]    key_left, key_left_next;
  logic [CB-1:0] msg_total, msg_total_next;
  logic [31:0]   message_limit;

  logic          proto_bad;
  logic          op_ok;
  logic [63:0]   len_src;
  logic          mask_src;
  logic [SB-1:0] total_w, lim_w, sum_w;
  logic          too_big;
  logic          sum_sat;
  logic [CB-1:0] total_sat;
  logic          known;
  logic          hdr_short;
  logic [7:0]    key_byte;

  assign op_ok = (in_byte[3:0] == wsfd_pkg::OP_CONT)  || (in_byte[3:0] == wsfd_pkg::OP_TEXT) ||
                 (in_byte[3:0] == wsfd_pkg::OP_BIN)   || (in_byte[3:0] == wsfd_pkg::OP_CLOSE) ||
                 (in_byte[3:0] == wsfd_pkg::OP_PING)  || (in_byte[3:0] == wsfd_pkg::OP_PONG);
  assign proto_bad = (in_byte[6:4] != 3'd0) || !op_ok;

  assign hdr_short = (in_byte[6:0] != wsfd_pkg::LEN_EXT16) &&
                     (in_byte[6:0] != wsfd_pkg::LEN_EXT64);
  assign known = ((phase == wsfd_pkg::PH_HDR2) && hdr_short) ||
                 ((phase == wsfd_pkg::PH_EXTLEN) && (ext_left == 4'd1));

  assign len_src  = (phase == wsfd_pkg::PH_HDR2) ? {57'd0, in_byte[6:0]}
                                                 : {frame_length[55:0], in_byte};
  assign mask_src = (phase == wsfd_pkg::PH_HDR2) ? in_byte[7] : masked;

  assign total_w = {{(SB-CB){1'b0}}, msg_total};
  assign lim_w   = {{(SB-32){1'b0}}, message_limit};
  assign sum_w   = total_w + {1'b0, len_src};
  assign too_big = (total_w > lim_w) || (sum_w > lim_w);
  assign sum_sat = (sum_w[SB-1:CB] != '0);
  assign total_sat = sum_sat ? {CB{1'b1}} : sum_w[CB-1:0];

  assign key_byte = (key_idx == 2'd0) ? key_word[31:24] :
                    (key_idx == 2'd1) ? key_word[23:16] :
                    (key_idx == 2'd2) ? key_word[15:8]  : key_word[7:0];

  always_comb begin
    phase_next = phase;
    if (in_valid) begin
      case (phase)
        wsfd_pkg::PH_HDR1: begin
          phase_next = proto_bad ? wsfd_pkg::PH_DISCARD : wsfd_pkg::PH_HDR2;
        end
        wsfd_pkg::PH_HDR2, wsfd_pkg::PH_EXTLEN: begin
          if (known) begin
            if (too_big) phase_next = wsfd_pkg::PH_DISCARD;
            else if (mask_src) phase_next = wsfd_pkg::PH_KEY;
            else if (len_src == 64'd0) phase_next = wsfd_pkg::PH_HDR1;
            else phase_next = wsfd_pkg::PH_PAYLOAD;
          end else begin
            phase_next = wsfd_pkg::PH_EXTLEN;
          end
        end
        wsfd_pkg::PH_KEY: begin
          if (key_left == 3'd1) begin
            phase_next = (frame_length == 64'd0) ? wsfd_pkg::PH_HDR1 : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          if (bytes_left == 64'd1) phase_next = wsfd_pkg::PH_HDR1;
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    fin_seen_next     = fin_seen;
    cur_op_next       = cur_op;
    masked_next       = masked;
    ext_left_next     = ext_left;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    key_idx_next      = key_idx;
    key_word_next     = key_word;
    key_left_next     = key_left;
    msg_total_next    = msg_total;
    res_valid         = 1'b0;
    res.status        = wsfd_pkg::ST_DATA;
    res.data_byte     = 8'd0;
    res.frame_opcode  = cur_op;
    res.frame_end     = 1'b0;
    res.final_frame   = fin_seen;
    if (in_valid) begin
      case (phase)
        wsfd_pkg::PH_HDR1: begin
          fin_seen_next = in_byte[7];
          cur_op_next   = in_byte[3:0];
          key_word_next = 32'd0;
          if (proto_bad) begin
            res_valid        = 1'b1;
            res.status       = wsfd_pkg::ST_PROTO;
            res.frame_opcode = in_byte[3:0];
            res.final_frame  = in_byte[7];
          end
        end
        wsfd_pkg::PH_HDR2, wsfd_pkg::PH_EXTLEN: begin
          if (phase == wsfd_pkg::PH_HDR2) begin
            masked_next = in_byte[7];
            ext_left_next = (in_byte[6:0] == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                                  : wsfd_pkg::EXT64_BYTES;
            frame_length_next = hdr_short ? len_src : 64'd0;
          end else begin
            ext_left_next     = ext_left - 4'd1;
            frame_length_next = len_src;
          end
          if (known) begin
            if (too_big) begin
              res_valid  = 1'b1;
              res.status = wsfd_pkg::ST_BIG;
            end else begin
              msg_total_next  = total_sat;
              bytes_left_next = len_src;
              key_idx_next    = 2'd0;
              if (mask_src) begin
                key_left_next = wsfd_pkg::KEY_BYTES;
              end else if (len_src == 64'd0) begin
                res_valid     = 1'b1;
                res.status    = wsfd_pkg::ST_EMPTY;
                res.frame_end = 1'b1;
                if (fin_seen) msg_total_next = '0;
              end
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_word_next = {key_word[23:0], in_byte};
          key_left_next = key_left - 3'd1;
          if ((key_left == 3'd1) && (frame_length == 64'd0)) begin
            res_valid     = 1'b1;
            res.status    = wsfd_pkg::ST_EMPTY;
            res.frame_end = 1'b1;
            if (fin_seen) msg_total_next = '0;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          res_valid       = 1'b1;
          res.data_byte   = in_byte ^ key_byte;
          res.frame_end   = (bytes_left == 64'd1);
          bytes_left_next = bytes_left - 64'd1;
          key_idx_next    = key_idx + 2'd1;
          if ((bytes_left == 64'd1) && fin_seen) msg_total_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsfd_pkg::PH_HDR1;
      fin_seen      <= 1'b0;
      cur_op        <= 4'd0;
      masked        <= 1'b0;
      ext_left      <= 4'd0;
      frame_length  <= 64'd0;
      bytes_left    <= 64'd0;
      key_idx       <= 2'd0;
      key_word      <= 32'd0;
      key_left      <= 3'd0;
      msg_total     <= '0;
      message_limit <= 32'hFFFF_FFFF;
    end else begin
      phase        <= phase_next;
      fin_seen     <= fin_seen_next;
      cur_op       <= cur_op_next;
      masked       <= masked_next;
      ext_left     <= ext_left_next;
      frame_length <= frame_length_next;
      bytes_left   <= bytes_left_next;
      key_idx      <= key_idx_next;
      key_word     <= key_word_next;
      key_left     <= key_left_next;
      msg_total    <= msg_total_next;
      if (cfg_write) message_limit <= cfg_limit;
    end
  end

endmodule

FILE: hw/rtl/wsfd_out_queue.sv
// Two-entry result register with skid slot.
module wsfd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsfd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output wsfd_pkg::result_t out_data
);

  wsfd_pkg::result_t slot0, slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11: count <= count;
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_data;
        end else begin
          slot0 <= slot1;
          slot1 <= push_data;
        end
      end
      2'b10: begin
        if (count == 2'd0) slot0 <= push_data;
        else slot1 <= push_data;
      end
      2'b01: slot0 <= slot1;
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/websocket_frame_decoder.sv
// Top level of the WebSocket frame decoder.
// A result is registered in the output queue before it is presented.
// Throughput: one byte per cycle while the result queue has space; the parser state updates on each accepted byte.
// A two-entry result queue keeps input flowing while one result is stalled.
// Reset (synchronous, rst high) returns to the first header byte, clears the
// message total and the queue, and sets message_limit to all ones.
module websocket_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] frame_opcode, [12] final_frame
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // message_limit
);

  logic              in_xfer;
  logic              res_valid;
  logic              space;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t out_res;

  assign s_axis_tready = space;
  assign in_xfer       = s_axis_tvalid && space;
  assign cfg_ready     = 1'b1;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_xfer),
    .in_byte   (s_axis_tdata),
    .cfg_write (cfg_valid),
    .cfg_limit (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {3'd0, out_res.final_frame, out_res.frame_opcode, out_res.data_byte};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.frame_end;

endmodule
